FILE: rtl/ten_bit_sample_pack_unpack_assert.svh
// Assertion macros shared by the ten-bit sample pack/unpack RTL.
// Depends on nothing; the asserting modules include it by file name.
`ifndef TEN_BIT_SAMPLE_PACK_UNPACK_ASSERT_SVH
`define TEN_BIT_SAMPLE_PACK_UNPACK_ASSERT_SVH

`ifndef SYNTH
// Clocked assertion with an explicit clock and reset.
`define TBSP_ASSERT_CR(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Clocked assertion on the module's own clk and rst.
`define TBSP_ASSERT(lbl, prop, msg) \
  `TBSP_ASSERT_CR(lbl, clk, rst, prop, msg)
`else
`define TBSP_ASSERT_CR(lbl, ck, rs, prop, msg)
`define TBSP_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/tbsp_pkg.sv
// Shared types and constants for the ten-bit sample pack/unpack block.
// Used by the front end, the queue, the back end and the top level.
`timescale 1ns / 1ps

package tbsp_pkg;

  // Width of one input or output word.
  localparam int WORD_W = 16;

  // Depth of the queue between front and back, and the widths derived from it.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration address width and register index of the mode register.
  localparam int PADDR_W = 3;
  localparam logic REG_PACK_MODE = 1'b0;

  // Configuration seen by the front end.
  typedef struct packed {
    logic pack_mode;
    logic clear;
  } cfg_t;

  // One queued job: one or two output words produced by one input word.
  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic              two_words;
  } entry_t;

endpackage

FILE: rtl/tbsp_front.sv
// Front end: accepts input words, keeps the group phase and carried bits,
// and turns each word that yields a result into a queue entry. Depends on tbsp_pkg.
`timescale 1ns / 1ps
`include "ten_bit_sample_pack_unpack_assert.svh"

module tbsp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  tbsp_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [tbsp_pkg::WORD_W-1:0] data_in,
  input  logic                      queue_full,
  output logic                      push,
  output tbsp_pkg::entry_t          push_entry
);
  import tbsp_pkg::*;

  localparam logic [2:0] PHASE_FIRST  = 3'd0;
  localparam logic [2:0] PHASE_SECOND = 3'd1;
  localparam logic [2:0] PHASE_THIRD  = 3'd2;
  localparam logic [2:0] PHASE_FOURTH = 3'd3;
  localparam logic [2:0] PHASE_FIFTH  = 3'd4;

  logic [2:0] group_phase;
  logic [7:0] carry_bits;
  logic [2:0] group_phase_next;
  logic [7:0] carry_bits_next;
  logic       accept;
  logic       round_up;
  logic [9:0] pack_code;
  logic [9:0] unpack_code;
  logic [7:0] byte_in;
  logic       has_result;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign byte_in  = data_in[7:0];

  // Sample to code: arithmetic shift by six, corrected toward zero, plus 512.
  assign round_up  = data_in[15] && (data_in[5:0] != 6'd0);
  assign pack_code = {~data_in[15], data_in[14:6]} + {9'd0, round_up};

  // Work out the entry and the next state for the word on the input.
  always_comb begin
    group_phase_next = group_phase;
    carry_bits_next  = carry_bits;
    unpack_code      = 10'd0;
    has_result       = 1'b1;
    push_entry       = '0;
    if (cfg.pack_mode) begin
      case (group_phase)
        PHASE_SECOND: begin
          push_entry.word0 = {8'd0, carry_bits[1:0], pack_code[9:4]};
          carry_bits_next  = {4'd0, pack_code[3:0]};
          group_phase_next = PHASE_THIRD;
        end
        PHASE_THIRD: begin
          push_entry.word0 = {8'd0, carry_bits[3:0], pack_code[9:6]};
          carry_bits_next  = {2'd0, pack_code[5:0]};
          group_phase_next = PHASE_FOURTH;
        end
        PHASE_FOURTH: begin
          push_entry.word0     = {8'd0, carry_bits[5:0], pack_code[9:8]};
          push_entry.word1     = {8'd0, pack_code[7:0]};
          push_entry.two_words = 1'b1;
          carry_bits_next      = 8'd0;
          group_phase_next     = PHASE_FIRST;
        end
        default: begin
          push_entry.word0 = {8'd0, pack_code[9:2]};
          carry_bits_next  = {6'd0, pack_code[1:0]};
          group_phase_next = PHASE_SECOND;
        end
      endcase
    end else begin
      case (group_phase)
        PHASE_SECOND: begin
          unpack_code      = {carry_bits, byte_in[7:6]};
          carry_bits_next  = {2'd0, byte_in[5:0]};
          group_phase_next = PHASE_THIRD;
        end
        PHASE_THIRD: begin
          unpack_code      = {carry_bits[5:0], byte_in[7:4]};
          carry_bits_next  = {4'd0, byte_in[3:0]};
          group_phase_next = PHASE_FOURTH;
        end
        PHASE_FOURTH: begin
          unpack_code      = {carry_bits[3:0], byte_in[7:2]};
          carry_bits_next  = {6'd0, byte_in[1:0]};
          group_phase_next = PHASE_FIFTH;
        end
        PHASE_FIFTH: begin
          unpack_code      = {carry_bits[1:0], byte_in};
          carry_bits_next  = 8'd0;
          group_phase_next = PHASE_FIRST;
        end
        default: begin
          carry_bits_next  = byte_in;
          group_phase_next = PHASE_SECOND;
          has_result       = 1'b0;
        end
      endcase
      // Code to sample: (code - 512) * 64 in two's complement.
      push_entry.word0 = {~unpack_code[9], unpack_code[8:0], 6'd0};
    end
  end

  assign push = accept && has_result;

  // Group state; a mode write starts a fresh group.
  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      group_phase <= PHASE_FIRST;
      carry_bits  <= 8'd0;
    end else if (accept) begin
      group_phase <= group_phase_next;
      carry_bits  <= carry_bits_next;
    end
  end

  `TBSP_ASSERT(a_clear_restarts, cfg.clear |=> (group_phase == PHASE_FIRST && carry_bits == 8'd0),
    "mode write did not restart the group")
  `TBSP_ASSERT(a_pack_phase_range, cfg.pack_mode |-> (group_phase <= PHASE_FOURTH),
    "pack phase out of range")
  `TBSP_ASSERT(a_no_push_when_full, queue_full |-> !push,
    "front pushed into a full queue")

endmodule

FILE: rtl/tbsp_queue.sv
// Short queue of jobs between the front end and the back end.
// Depends on tbsp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`include "ten_bit_sample_pack_unpack_assert.svh"

module tbsp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tbsp_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output tbsp_pkg::entry_t head_entry
);
  import tbsp_pkg::*;

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TBSP_ASSERT(a_count_range, count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `TBSP_ASSERT(a_no_pop_empty, pop |-> head_valid, "pop from an empty queue")
  `TBSP_ASSERT(a_count_up, (push && !pop) |=> (count == $past(count) + 1'b1),
    "queue count did not follow a push")

endmodule

FILE: rtl/tbsp_back.sv
// Back end: takes jobs from the queue and sends their words one per cycle,
// unless out_stall holds them, through a registered output stage. Depends on tbsp_pkg.
`timescale 1ns / 1ps
`include "ten_bit_sample_pack_unpack_assert.svh"

module tbsp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  tbsp_pkg::entry_t            head_entry,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tbsp_pkg::WORD_W-1:0] data_out,
  output logic                        last
);
  import tbsp_pkg::*;

  logic              pend_valid;
  logic [WORD_W-1:0] pend_word;
  logic              advance;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !pend_valid && head_valid;

  // Output stage and the held second word of a two-word job.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= head_valid;
        pend_valid <= head_valid && head_entry.two_words;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_valid) begin
        data_out <= pend_word;
        last     <= 1'b1;
      end else begin
        data_out  <= head_entry.word0;
        last      <= !head_entry.two_words;
        pend_word <= head_entry.word1;
      end
    end
  end

  `TBSP_ASSERT(a_pend_needs_out, pend_valid |-> out_valid, "second word held with no first word")
  `TBSP_ASSERT(a_first_has_second, (out_valid && !last) |-> pend_valid,
    "first word of a pair without its second")
  `TBSP_ASSERT(a_second_follows, (out_valid && !last && !out_stall) |=> (out_valid && last),
    "second word did not follow the first")

endmodule

FILE: rtl/ten_bit_sample_pack_unpack.sv
// Ten-bit sample pack/unpack block.
// The input channel (in_valid, in_stall, data_in) takes one word per accepted
// cycle; the output channel (out_valid, out_stall, data_out, last) gives words.
// pack_mode (APB register at byte address 0) selects the direction: 1 packs
// signed 16-bit samples into bytes, four 10-bit codes in five bytes; 0 unpacks
// bytes into samples. Writing pack_mode restarts the group; write it only idle.
// A job is written into the queue and then loaded into the output stage,
// and out_stall may hold it there. Throughput: one input word per cycle
// while in_stall is low. The output stage sends one word per cycle unless
// stalled, so the second byte of a fourth pack sample delays the next job
// and in_stall can rise in pack mode; unpack mode takes one byte per cycle
// while in_stall is low. The first byte of each unpack group gives no result.
// last marks the final word caused by one input word.
// A two-entry queue lies between the front end and the output stage; when the
// receiver stalls the queue fills and in_stall rises once it is full.
// Reset clears the group state, the queue and the output stage and sets
// pack_mode to 0 (unpack).
// Depends on tbsp_pkg, tbsp_front, tbsp_queue and tbsp_back.
`timescale 1ns / 1ps

module ten_bit_sample_pack_unpack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbsp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tbsp_pkg::WORD_W-1:0]   data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tbsp_pkg::WORD_W-1:0]   data_out,
  output logic                          last
);
  import tbsp_pkg::*;

  logic   pack_mode;
  logic   mode_write;
  cfg_t   cfg;
  logic   queue_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  // Register port: one mode register.
  assign pready     = 1'b1;
  assign mode_write = psel && penable && pwrite && (paddr[2] == REG_PACK_MODE);
  assign prdata     = (paddr[2] == REG_PACK_MODE) ? {31'd0, pack_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_mode <= 1'b0;
    end else if (mode_write) begin
      pack_mode <= pwdata[0];
    end
  end

  assign cfg.pack_mode = pack_mode;
  assign cfg.clear     = mode_write;

  // Front end.
  tbsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_in    (data_in),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Job queue.
  tbsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Back end and output stage.
  tbsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .last       (last)
  );

endmodule
